[hw/rtl/snf_pkg.sv]
// Shared types, codes and default constants for the smoothed needle follower.
package snf_pkg;

   localparam int DEF_READING_LOW   = 400;
   localparam int DEF_READING_HIGH  = 2200;
   localparam int DEF_POSITION_BITS = 16;

   localparam int READING_W = 12;
   localparam int STEP_W    = 16;
   localparam int CSR_W     = 16;

   localparam logic signed [STEP_W-1:0] RESET_STEP_LOW  = 16'sd0;
   localparam logic signed [STEP_W-1:0] RESET_STEP_HIGH = 16'sd1024;
   localparam logic RESET_DIRECTION_REVERSE = 1'b0;
   localparam logic RESET_AUTO_ENABLE       = 1'b1;

   localparam logic [3:0] COIL_FIRST = 4'b0001;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_SYNC = 2'd2,
      OP_ZERO = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_STEP_LOW  = 2'd0,
      CSR_STEP_HIGH = 2'd1,
      CSR_DIR_REV   = 2'd2,
      CSR_AUTO_EN   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_LOW  = 2'd0,
      REGION_HIGH = 2'd1,
      REGION_MID  = 2'd2
   } region_type;

   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic [READING_W-1:0] display;
      region_type           region;
   } smooth_stage_type;

   typedef struct packed {
      logic                       valid;
      op_type                     op;
      logic [READING_W-1:0]       display;
      logic signed [STEP_W-1:0]   goal;
   } goal_stage_type;

endpackage

[hw/rtl/smoothed_stepper_needle_follower_top.sv]
// Top level of the smoothed stepper needle follower with its register file.
// The result of an item appears on the result ports once the item has passed six
// registers: input register, smoothing stage, mapping multiply, reciprocal multiply, goal
// sum, and the result register that holds the motor state update. One item is accepted
// every cycle while the result side takes results; the chain of stage registers absorbs a
// stalled result.
// Configuration registers must be written only while no item is in flight.
module smoothed_stepper_needle_follower_top
   import snf_pkg::*;
#(
   parameter int READING_LOW   = DEF_READING_LOW,
   parameter int READING_HIGH  = DEF_READING_HIGH,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [15:0]              req_reading,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [3:0]               rsp_coil_drive,
   output logic signed [STEP_W-1:0] rsp_motor_position,
   output logic [READING_W-1:0]     rsp_shown_reading,
   output logic                     rsp_stepped,
   output logic                     rsp_arrived,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   logic signed [STEP_W-1:0] step_low_ff, step_high_ff;
   logic                     dir_rev_ff, auto_en_ff;

   smooth_stage_type smooth_stage;
   goal_stage_type   goal_stage;
   logic             map_ready, drive_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_low_ff  <= RESET_STEP_LOW;
         step_high_ff <= RESET_STEP_HIGH;
         dir_rev_ff   <= RESET_DIRECTION_REVERSE;
         auto_en_ff   <= RESET_AUTO_ENABLE;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_LOW:  step_low_ff  <= $signed(csr_data[STEP_W-1:0]);
            CSR_STEP_HIGH: step_high_ff <= $signed(csr_data[STEP_W-1:0]);
            CSR_DIR_REV:   dir_rev_ff   <= csr_data[0];
            CSR_AUTO_EN:   auto_en_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   snf_front #(
      .READING_LOW  (READING_LOW),
      .READING_HIGH (READING_HIGH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_reading (req_reading),
      .next_ready  (map_ready),
      .stage_out   (smooth_stage)
   );

   snf_map #(
      .READING_LOW  (READING_LOW),
      .READING_HIGH (READING_HIGH)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (smooth_stage),
      .prev_ready (map_ready),
      .next_ready (drive_ready),
      .step_low   (step_low_ff),
      .step_high  (step_high_ff),
      .stage_out  (goal_stage)
   );

   snf_drive #(
      .POSITION_BITS (POSITION_BITS)
   ) u_drive (
      .clock              (clock),
      .reset              (reset),
      .stage_in           (goal_stage),
      .prev_ready         (drive_ready),
      .direction_reverse  (dir_rev_ff),
      .auto_enable        (auto_en_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coil_drive     (rsp_coil_drive),
      .rsp_motor_position (rsp_motor_position),
      .rsp_shown_reading  (rsp_shown_reading),
      .rsp_stepped        (rsp_stepped),
      .rsp_arrived        (rsp_arrived)
   );

endmodule

[hw/rtl/snf_front.sv]
// Input register, target and display state, and the smoothing stage.
module snf_front
   import snf_pkg::*;
#(
   parameter int READING_LOW  = DEF_READING_LOW,
   parameter int READING_HIGH = DEF_READING_HIGH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_op,
   input  logic [15:0]      req_reading,
   input  logic             next_ready,
   output smooth_stage_type stage_out
);

   localparam logic signed [16:0] LOW_S  = 17'(READING_LOW);
   localparam logic signed [16:0] HIGH_S = 17'(READING_HIGH);
   localparam logic [READING_W-1:0] RESET_READING = (READING_LOW > READING_HIGH) ?
      READING_W'(READING_HIGH) : READING_W'(READING_LOW);
   localparam logic SPAN_POS = (READING_HIGH > READING_LOW);
   localparam logic [15:0] DIV10_RECIP = 16'd52429;
   localparam int DIV10_SHIFT = 19;

   function automatic logic [READING_W-1:0] clamp_reading(input logic signed [16:0] r);
      logic signed [16:0] v;
      v = r;
      if (v < LOW_S) begin
         v = LOW_S;
      end
      if (v > HIGH_S) begin
         v = HIGH_S;
      end
      return v[READING_W-1:0];
   endfunction

   logic                 in_valid_ff, in_valid_in;
   op_type               in_op_ff;
   logic [15:0]          in_reading_ff;
   logic [READING_W-1:0] target_ff, target_in;
   logic [READING_W-1:0] display_ff, display_in;
   smooth_stage_type     stage_ff, stage_in;

   logic                 stage_ready, in_ready, in_move;
   logic [READING_W-1:0] clamped, smoothed;
   logic signed [13:0]   diff, nudge, step, sum;
   logic [12:0]          mag;
   logic [28:0]          quot_full;
   logic [9:0]           quot;
   region_type           region;

   always_comb begin
      stage_ready = !stage_ff.valid || next_ready;
      in_ready    = !in_valid_ff || stage_ready;
      in_move     = in_valid_ff && stage_ready;
      req_stall   = !in_ready;

      clamped   = clamp_reading($signed({1'b0, in_reading_ff}));
      diff      = $signed({2'b00, target_ff}) - $signed({2'b00, display_ff});
      nudge     = diff + 14'sd5;
      mag       = nudge[13] ? 13'(-nudge) : nudge[12:0];
      quot_full = mag * DIV10_RECIP;
      quot      = quot_full[DIV10_SHIFT +: 10];
      step      = nudge[13] ? -$signed({4'b0000, quot}) : $signed({4'b0000, quot});
      sum       = $signed({2'b00, display_ff}) + step;
      smoothed  = clamp_reading({{3{sum[13]}}, sum});

      target_in  = target_ff;
      display_in = display_ff;
      if (in_move) begin
         case (in_op_ff)
            OP_SET: begin
               target_in = clamped;
            end
            OP_SYNC: begin
               target_in  = clamped;
               display_in = clamped;
            end
            OP_TICK: begin
               display_in = smoothed;
            end
            default: begin
            end
         endcase
      end

      if ($signed({5'b00000, display_in}) <= LOW_S) begin
         region = REGION_LOW;
      end else if (($signed({5'b00000, display_in}) >= HIGH_S) || !SPAN_POS) begin
         region = REGION_HIGH;
      end else begin
         region = REGION_MID;
      end

      stage_in = stage_ff;
      if (stage_ready) begin
         stage_in.valid = in_valid_ff;
      end
      if (in_move) begin
         stage_in.op      = in_op_ff;
         stage_in.display = display_in;
         stage_in.region  = region;
      end

      in_valid_in = in_ready ? req_valid : in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         target_ff      <= RESET_READING;
         display_ff     <= RESET_READING;
         stage_ff.valid <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         target_ff   <= target_in;
         display_ff  <= display_in;
         stage_ff    <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_op_ff      <= op_type'(req_op);
         in_reading_ff <= req_reading;
      end
   end

   assign stage_out = stage_ff;

endmodule

[hw/rtl/snf_map.sv]
// Linear mapping of the display reading onto the calibrated step range.
module snf_map
   import snf_pkg::*;
#(
   parameter int READING_LOW  = DEF_READING_LOW,
   parameter int READING_HIGH = DEF_READING_HIGH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smooth_stage_type         stage_in,
   output logic                     prev_ready,
   input  logic                     next_ready,
   input  logic signed [STEP_W-1:0] step_low,
   input  logic signed [STEP_W-1:0] step_high,
   output goal_stage_type           stage_out
);

   localparam int SPAN_RD = READING_HIGH - READING_LOW;
   localparam int DIVISOR = (SPAN_RD > 0) ? SPAN_RD : 1;
   localparam int SHIFT   = 28 + $clog2(DIVISOR);
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [28:0] RECIP = 29'(RECIP_FULL);
   localparam logic [READING_W-1:0] LOW_R = READING_W'(READING_LOW);

   logic                 mul_valid_ff;
   op_type               mul_op_ff;
   logic [READING_W-1:0] mul_display_ff;
   region_type           mul_region_ff;
   logic signed [28:0]   mul_prod_ff;

   logic                 rcp_valid_ff;
   op_type               rcp_op_ff;
   logic [READING_W-1:0] rcp_display_ff;
   region_type           rcp_region_ff;
   logic                 rcp_neg_ff;
   logic [42:0]          rcp_lo_ff;
   logic [41:0]          rcp_hi_ff;

   goal_stage_type       goal_ff, goal_in;

   logic                 goal_ready, rcp_ready, mul_ready;
   logic [READING_W-1:0] offset;
   logic signed [16:0]   span;
   logic signed [29:0]   prod_full;
   logic [27:0]          mag;
   logic [42:0]          pp_lo;
   logic [41:0]          pp_hi;
   logic [57:0]          full;
   logic [16:0]          quo;
   logic signed [17:0]   quo_s, goal_mid;

   always_comb begin
      goal_ready = !goal_ff.valid || next_ready;
      rcp_ready  = !rcp_valid_ff || goal_ready;
      mul_ready  = !mul_valid_ff || rcp_ready;
      prev_ready = mul_ready;

      offset    = stage_in.display - LOW_R;
      span      = $signed({step_high[STEP_W-1], step_high})
                - $signed({step_low[STEP_W-1], step_low});
      prod_full = $signed({1'b0, offset}) * span;

      mag   = mul_prod_ff[28] ? 28'(-mul_prod_ff) : mul_prod_ff[27:0];
      pp_lo = mag * RECIP[14:0];
      pp_hi = mag * RECIP[28:15];

      full     = 58'(rcp_lo_ff) + 58'({rcp_hi_ff, 15'd0});
      quo      = full[SHIFT +: 17];
      quo_s    = rcp_neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      goal_mid = $signed({{2{step_low[STEP_W-1]}}, step_low}) + quo_s;

      goal_in = goal_ff;
      if (goal_ready) begin
         goal_in.valid = rcp_valid_ff;
      end
      if (rcp_valid_ff && goal_ready) begin
         goal_in.op      = rcp_op_ff;
         goal_in.display = rcp_display_ff;
         case (rcp_region_ff)
            REGION_LOW:  goal_in.goal = step_low;
            REGION_MID:  goal_in.goal = goal_mid[STEP_W-1:0];
            default:     goal_in.goal = step_high;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff  <= 1'b0;
         rcp_valid_ff  <= 1'b0;
         goal_ff.valid <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= stage_in.valid;
         end
         if (rcp_ready) begin
            rcp_valid_ff <= mul_valid_ff;
         end
         goal_ff <= goal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_in.valid && mul_ready) begin
         mul_op_ff      <= stage_in.op;
         mul_display_ff <= stage_in.display;
         mul_region_ff  <= stage_in.region;
         mul_prod_ff    <= prod_full[28:0];
      end
      if (mul_valid_ff && rcp_ready) begin
         rcp_op_ff      <= mul_op_ff;
         rcp_display_ff <= mul_display_ff;
         rcp_region_ff  <= mul_region_ff;
         rcp_neg_ff     <= mul_prod_ff[28];
         rcp_lo_ff      <= pp_lo;
         rcp_hi_ff      <= pp_hi;
      end
   end

   assign stage_out = goal_ff;

endmodule

[hw/rtl/snf_drive.sv]
// Motor position, phase and coil state, and the result register.
module snf_drive
   import snf_pkg::*;
#(
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  goal_stage_type           stage_in,
   output logic                     prev_ready,
   input  logic                     direction_reverse,
   input  logic                     auto_enable,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [3:0]               rsp_coil_drive,
   output logic signed [STEP_W-1:0] rsp_motor_position,
   output logic [READING_W-1:0]     rsp_shown_reading,
   output logic                     rsp_stepped,
   output logic                     rsp_arrived
);

   localparam int CMP_W = 33;

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [1:0]               phase_ff, phase_in;
   logic [3:0]               coil_ff, coil_in;

   logic                     out_valid_ff, out_valid_in;
   logic [3:0]               out_coil_ff;
   logic signed [STEP_W-1:0] out_position_ff;
   logic [READING_W-1:0]     out_shown_ff;
   logic                     out_stepped_ff, out_arrived_ff;

   logic                     out_ready, move, take_step, up, fwd, arrived;
   logic signed [CMP_W-1:0]  here, goal, after;

   always_comb begin
      out_ready  = !out_valid_ff || !rsp_stall;
      move       = stage_in.valid && out_ready;
      prev_ready = out_ready;

      here      = CMP_W'($signed(position_ff));
      goal      = CMP_W'($signed(stage_in.goal));
      take_step = (stage_in.op == OP_TICK) && auto_enable && (here != goal);
      up        = goal > here;
      fwd       = direction_reverse ? !up : up;

      position_in = position_ff;
      phase_in    = phase_ff;
      coil_in     = coil_ff;
      if (stage_in.op == OP_ZERO) begin
         position_in = '0;
      end else if (take_step) begin
         phase_in    = fwd ? phase_ff + 2'd1 : phase_ff - 2'd1;
         coil_in     = COIL_FIRST << phase_in;
         position_in = up ? position_ff + POSITION_BITS'(1)
                          : position_ff - POSITION_BITS'(1);
      end
      after   = CMP_W'($signed(position_in));
      arrived = take_step && (after == goal);

      out_valid_in = out_ready ? stage_in.valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         phase_ff     <= 2'd0;
         coil_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (move) begin
            position_ff <= position_in;
            phase_ff    <= phase_in;
            coil_ff     <= coil_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_coil_ff     <= coil_in;
         out_position_ff <= after[STEP_W-1:0];
         out_shown_ff    <= stage_in.display;
         out_stepped_ff  <= take_step;
         out_arrived_ff  <= arrived;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_coil_drive     = out_coil_ff;
   assign rsp_motor_position = out_position_ff;
   assign rsp_shown_reading  = out_shown_ff;
   assign rsp_stepped        = out_stepped_ff;
   assign rsp_arrived        = out_arrived_ff;

`ifndef SYNTHESIS
   a_arrived_needs_step: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_arrived_ff |-> out_stepped_ff)
      else $error("Arrival reported without a step.");

   a_step_coil_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stepped_ff |-> $onehot(out_coil_ff))
      else $error("Stepped item carries a coil pattern that is not one-hot.");

   a_coil_matches_phase: assert property (@(posedge clock) disable iff (reset)
      (coil_ff == 4'd0) || (coil_ff == (COIL_FIRST << phase_ff)))
      else $error("Coil pattern does not follow the phase index.");

   a_step_moves_one: assert property (@(posedge clock) disable iff (reset)
      move && take_step |=>
         (POSITION_BITS'(position_ff - $past(position_ff)) == POSITION_BITS'(1)) ||
         (POSITION_BITS'(position_ff - $past(position_ff)) == {POSITION_BITS{1'b1}}))
      else $error("A step moved the position by other than one.");
`endif

endmodule
